@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on every rising edge outside reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/mme_pkg.sv @@
// ---------------------------------------------------------------------------
// mme_pkg
// shared types and codes of the matrix multiply engine
// ---------------------------------------------------------------------------
package mme_pkg;

    // item function codes
    localparam logic [1:0] FUNC_WR_A  = 2'd0;
    localparam logic [1:0] FUNC_WR_B  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_A_ROWS  = 3'd0;
    localparam logic [2:0] CFG_A_COLS  = 3'd1;
    localparam logic [2:0] CFG_B_ROWS  = 3'd2;
    localparam logic [2:0] CFG_B_COLS  = 3'd3;
    localparam logic [2:0] CFG_TRANS_B = 3'd4;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 36;

    // control that travels alongside the store read data into the mac
    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

endpackage

@@ rtl/core/mme_ram.sv @@
// ---------------------------------------------------------------------------
// mme_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mme_mac.sv @@
// ---------------------------------------------------------------------------
// mme_mac
// registered q4.12 multiply followed by an exact q12.24 accumulator
// ---------------------------------------------------------------------------
module mme_mac
    import mme_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_busy
);

    t_mac_ctl                  r_ctl1;
    t_mac_ctl                  r_ctl2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   w_prod_ext;

    // ctl1 lines up with the ram read data, ctl2 with the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (r_ctl1.valid) begin
            r_prod <= i_a * i_b;
        end
        if (r_ctl2.valid) begin
            r_acc <= (r_ctl2.first ? '0 : r_acc) + w_prod_ext;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_ctl1.valid | r_ctl2.valid;

endmodule

@@ rtl/core/matrix_multiply_engine.sv @@
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// dense q4.12 matrix multiply over two element stores, row-major results
// ---------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries one item per handshake:
//   func 0 writes an element of a, func 1 an element of b, func 2 starts a
//   multiply, func 3 is dropped. writes outside the configured sizes are
//   dropped too. loads give no result.
//   a start emits a_rows x b_cols products (a_rows x b_rows in transpose
//   mode) in row-major order on the output channel (o_out_valid /
//   i_out_stall), the final one flagged by o_last. a dimension mismatch
//   gives a single item with o_error and o_last set and a zero product.
// timing:
//   each product makes one store read per term through the single read port
//   of each store and the shared mac; each term passes the read register and
//   the product register, and the finished sum moves to the output register
//   before the next product's terms begin. the input is stalled from the
//   start until the last product is loaded.
// reset:
//   synchronous, active low; sizes return to 2x1 and 1x1, transpose off.
//   the stores are not cleared and must be written before they are read.
// stall:
//   a stalled output item holds; the engine waits with the next sum ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [3:0]              i_cfg_data,
    // input item channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_func,
    input  logic [2:0]              i_row,
    input  logic [2:0]              i_col,
    input  logic signed [VAL_W-1:0] i_value,
    // result item channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_out_row,
    output logic [2:0]              o_out_col,
    output logic signed [ACC_W-1:0] o_product,
    output logic                    o_last,
    output logic                    o_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_ERR   = 4'b1000
    } t_state;

    // size register to effective dimension: zero acts as one, clamp at max
    function automatic logic [DW-1:0] eff_dim(input logic [3:0] raw);
        logic [DW-1:0] res;
        if (raw == 4'd0) begin
            res = DW'(1);
        end else if (raw > 4'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(raw);
        end
        return res;
    endfunction

    // row-major store address
    function automatic logic [AW-1:0] st_addr(input logic [2:0] r, input logic [2:0] c);
        return AW'(r) * AW'(MAX_DIM) + AW'(c);
    endfunction

    // configuration registers
    logic [3:0]  r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic        r_trans;

    // sequencer
    t_state      r_state, n_state;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_row, n_out_row, r_out_col, n_out_col;
    logic signed [ACC_W-1:0] r_out_prod, n_out_prod;
    logic              r_out_last, n_out_last, r_out_err, n_out_err;

    // effective sizes
    logic [DW-1:0] w_ar, w_ac, w_br, w_bc, w_oc;
    logic          w_mismatch;

    // datapath hookup
    logic          w_in_acc, w_slot_free, w_last_k, w_last_elem;
    logic          w_we_a, w_we_b;
    logic [AW-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic signed [VAL_W-1:0] w_rd_a, w_rd_b;
    logic signed [ACC_W-1:0] w_acc;
    logic          w_mac_busy;
    t_mac_ctl      w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= 4'd2;
            r_a_cols <= 4'd1;
            r_b_rows <= 4'd1;
            r_b_cols <= 4'd1;
            r_trans  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_A_ROWS:  r_a_rows <= i_cfg_data;
                CFG_A_COLS:  r_a_cols <= i_cfg_data;
                CFG_B_ROWS:  r_b_rows <= i_cfg_data;
                CFG_B_COLS:  r_b_cols <= i_cfg_data;
                CFG_TRANS_B: r_trans  <= i_cfg_data[0];
                default: ; // unused indexes are ignored
            endcase
        end
    end

    assign w_ar = eff_dim(r_a_rows);
    assign w_ac = eff_dim(r_a_cols);
    assign w_br = eff_dim(r_b_rows);
    assign w_bc = eff_dim(r_b_cols);
    assign w_oc = r_trans ? w_br : w_bc;
    assign w_mismatch = r_trans ? (w_ac != w_bc) : (w_ac != w_br);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    // element loads go straight into the stores while idle
    assign w_waddr = st_addr(i_row, i_col);
    assign w_we_a  = w_in_acc && (i_func == FUNC_WR_A)
                     && (4'(i_row) < 4'(w_ar)) && (4'(i_col) < 4'(w_ac));
    assign w_we_b  = w_in_acc && (i_func == FUNC_WR_B)
                     && (4'(i_row) < 4'(w_br)) && (4'(i_col) < 4'(w_bc));

    // term k of element (i,j): a[i][k] times b[k][j], or b[j][k] transposed
    assign w_raddr_a = st_addr(3'(r_i), 3'(r_k));
    assign w_raddr_b = r_trans ? st_addr(3'(r_j), 3'(r_k)) : st_addr(3'(r_k), 3'(r_j));

    mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .o_acc   (w_acc),
        .o_busy  (w_mac_busy)
    );

    assign w_slot_free = ~r_out_valid | ~i_out_stall;
    assign w_last_k    = (DW'(r_k) + DW'(1)) == w_ac;
    assign w_last_elem = ((DW'(r_i) + DW'(1)) == w_ar) && ((DW'(r_j) + DW'(1)) == w_oc);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_prod  = r_out_prod;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_func == FUNC_START)) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    n_state = w_mismatch ? S_ERR : S_MAC;
                end
            end
            S_MAC: begin
                // one term read from each store per cycle
                w_ctl.valid = 1'b1;
                w_ctl.first = (r_k == '0);
                if (w_last_k) begin
                    n_k     = '0;
                    n_state = S_FLUSH;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_FLUSH: begin
                // wait for the last term to land and the output slot to free, then hand the sum over
                if (!w_mac_busy && w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = 3'(r_i);
                    n_out_col   = 3'(r_j);
                    n_out_prod  = w_acc;
                    n_out_last  = w_last_elem;
                    n_out_err   = 1'b0;
                    if (w_last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MAC;
                        if ((DW'(r_j) + DW'(1)) == w_oc) begin
                            n_j = '0;
                            n_i = r_i + IW'(1);
                        end else begin
                            n_j = r_j + IW'(1);
                        end
                    end
                end
            end
            S_ERR: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = 3'd0;
                    n_out_col   = 3'd0;
                    n_out_prod  = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_prod <= n_out_prod;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_product   = r_out_prod;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

    // the mac pipeline is drained before the engine goes back to idle
    `AST_IMPL(a_idle_mac_empty, i_clk, i_rst_n, r_state == S_IDLE, !w_mac_busy)
    // an error item always closes its run
    `AST_IMPL(a_err_is_last, i_clk, i_rst_n, r_out_valid && r_out_err, r_out_last)
    // loading the final product ends the run on the next cycle
    `AST_NEXT(a_last_ends_run, i_clk, i_rst_n,
              (r_state == S_FLUSH) && n_out_valid && n_out_last && !r_out_last,
              r_state == S_IDLE)

endmodule

@@ verif/matrix_multiply_engine_test.sv @@
// ---------------------------------------------------------------------------
// matrix_multiply_engine_test
// self-checking bench for the q4.12 matrix multiply engine: a cycle-free
// model of both stores and the size registers predicts every product item,
// and a checker compares each accepted result against the oldest one due
// ---------------------------------------------------------------------------
module matrix_multiply_engine_test;
    import mme_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int RANDOM_ITEMS  = 350;
    localparam int HOLD_CYCLES   = 400;        // long output hold-off
    localparam int SETTLE_CYCLES = 2 * (MAX_DIM + 3);
    localparam int DRAIN_BOUND   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam longint LIMIT_TIME = 64'd200_000_000;

    // function code that the block drops
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // one product item as seen on the result channel
    typedef struct {
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [ACC_W-1:0] product;
        logic                    last;
        logic                    error;
    } t_product;

    // ports of the block
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [2:0]              i_cfg_index;
    logic [3:0]              i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [1:0]              i_func;
    logic [2:0]              i_row;
    logic [2:0]              i_col;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [2:0]              o_out_row;
    logic [2:0]              o_out_col;
    logic signed [ACC_W-1:0] o_product;
    logic                    o_last;
    logic                    o_error;

    // shadow copy of the size registers and both element stores
    logic [3:0]              m_a_rows;
    logic [3:0]              m_a_cols;
    logic [3:0]              m_b_rows;
    logic [3:0]              m_b_cols;
    logic                    m_trans;
    logic signed [VAL_W-1:0] a_mem [STORE_DEPTH];
    logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];
    bit                      a_set [STORE_DEPTH];
    bit                      b_set [STORE_DEPTH];

    // products predicted but not yet seen, oldest first
    t_product                due_products [$];

    // run bookkeeping
    int  fault_count;
    int  live_items;
    int  starts_done;
    int  error_runs;
    int  products_seen;
    int  reg_writes;
    int  hold_cycles_done;
    bit  burst_mode;            // sender offers items back to back
    bit  hold_req;              // ask the receiver for one long hold-off
    bit  long_hold_active;

    matrix_multiply_engine #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_row(i_row),
        .i_col(i_col),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_row(o_out_row),
        .o_out_col(o_out_col),
        .o_product(o_product),
        .o_last(o_last),
        .o_error(o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(LIMIT_TIME);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // a size of 0 acts as 1, anything above the maximum as the maximum
    function automatic int eff_dim(input logic [3:0] raw);
        if (raw == 4'd0) begin
            return 1;
        end
        if (raw > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(raw);
    endfunction

    function automatic bit dims_agree();
        if (m_trans) begin
            return eff_dim(m_a_cols) == eff_dim(m_b_cols);
        end
        return eff_dim(m_a_cols) == eff_dim(m_b_rows);
    endfunction

    // full product of the stores under the current sizes, row-major, or one error item on a mismatch
    task automatic multiply_model();
        int       ar;
        int       ac;
        int       oc;
        longint   acc;
        t_product p;
        ar = eff_dim(m_a_rows);
        ac = eff_dim(m_a_cols);
        oc = m_trans ? eff_dim(m_b_rows) : eff_dim(m_b_cols);
        starts_done++;
        if (!dims_agree()) begin
            // mismatch gives one flagged item with a zero product
            p.row     = '0;
            p.col     = '0;
            p.product = '0;
            p.last    = 1'b1;
            p.error   = 1'b1;
            due_products = {due_products, p};
            error_runs++;
            return;
        end
        for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < oc; j++) begin
                acc = 0;
                for (int k = 0; k < ac; k++) begin
                    acc += longint'(a_mem[i * MAX_DIM + k]) *
                           longint'(m_trans ? b_mem[j * MAX_DIM + k]
                                            : b_mem[k * MAX_DIM + j]);
                end
                p.row     = 3'(i);
                p.col     = 3'(j);
                p.product = acc[ACC_W-1:0];
                p.last    = (i == ar - 1) && (j == oc - 1);
                p.error   = 1'b0;
                due_products = {due_products, p};
            end
        end
    endtask

    // model update for one accepted item
    task automatic accept_item(input logic [1:0] f, input logic [2:0] r,
                               input logic [2:0] c, input logic signed [VAL_W-1:0] v);
        int idx;
        idx = int'(r) * MAX_DIM + int'(c);
        case (f)
            FUNC_WR_A: begin
                if (r < eff_dim(m_a_rows) && c < eff_dim(m_a_cols)) begin
                    a_mem[idx] = v;
                    a_set[idx] = 1'b1;
                    live_items++;
                end
            end
            FUNC_WR_B: begin
                if (r < eff_dim(m_b_rows) && c < eff_dim(m_b_cols)) begin
                    b_mem[idx] = v;
                    b_set[idx] = 1'b1;
                    live_items++;
                end
            end
            FUNC_START: begin
                live_items++;
                multiply_model();
            end
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [2:0] idx, input logic [3:0] data);
        case (idx)
            CFG_A_ROWS:  m_a_rows = data;
            CFG_A_COLS:  m_a_cols = data;
            CFG_B_ROWS:  m_b_rows = data;
            CFG_B_COLS:  m_b_cols = data;
            CFG_TRANS_B: m_trans  = data[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // element values lean on the extremes of q4.12
    function automatic logic signed [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'(int'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 55) begin
            return 0;
        end
        if (pick < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [3:0] pick_size(input bit wide);
        if (wide) begin
            return 4'($urandom_range(0, 15));
        end
        return 4'($urandom_range(1, 3));
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] f, input logic [2:0] r,
                             input logic [2:0] c, input logic signed [VAL_W-1:0] v);
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_row      <= r;
        i_col      <= c;
        i_value    <= v;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        accept_item(f, r, c, v);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register writes only happen with the block idle
    task automatic write_reg(input logic [2:0] idx, input logic [3:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_config(idx, data);
        reg_writes++;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, let every due product arrive, then let the engine go quiet
    task automatic settle();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (due_products.size() != 0 && waited < DRAIN_BOUND);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // load whatever a multiply would read that was never written, then start
    task automatic run_multiply();
        if (dims_agree()) begin
            for (int r = 0; r < eff_dim(m_a_rows); r++) begin
                for (int c = 0; c < eff_dim(m_a_cols); c++) begin
                    if (!a_set[r * MAX_DIM + c]) begin
                        send_item(FUNC_WR_A, 3'(r), 3'(c), rand_value());
                    end
                end
            end
            // either mode reads all of b
            for (int r = 0; r < eff_dim(m_b_rows); r++) begin
                for (int c = 0; c < eff_dim(m_b_cols); c++) begin
                    if (!b_set[r * MAX_DIM + c]) begin
                        send_item(FUNC_WR_B, 3'(r), 3'(c), rand_value());
                    end
                end
            end
        end
        // row, col and value of a start carry no meaning
        send_item(FUNC_START, 3'($urandom), 3'($urandom), rand_value());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset sizes: 2x1 times 1x1, with the largest magnitudes
    task automatic test_default_sizes();
        send_item(FUNC_WR_A, 3'd0, 3'd0, 16'sh7fff);
        send_item(FUNC_WR_A, 3'd1, 3'd0, 16'sh8000);
        send_item(FUNC_WR_B, 3'd0, 3'd0, 16'sh8000);
        run_multiply();
        settle();
    endtask

    // writes past the sizes and the spare function code change nothing
    task automatic test_ignored_items();
        send_item(FUNC_WR_A, 3'd2, 3'd0, rand_value());
        send_item(FUNC_WR_A, 3'd0, 3'd7, rand_value());
        send_item(FUNC_WR_B, 3'd7, 3'd7, rand_value());
        send_item(FUNC_NONE, 3'd7, 3'd7, 16'shffff);
        run_multiply();
        settle();
    endtask

    // plain and transpose mismatch, plus writes to indexes with no register
    task automatic test_dimension_errors();
        for (int idx = CFG_TRANS_B + 1; idx < 8; idx++) begin
            write_reg(3'(idx), 4'($urandom));
        end
        write_reg(CFG_A_COLS, 4'd2);
        run_multiply();
        settle();
        write_reg(CFG_TRANS_B, 4'd1);
        write_reg(CFG_B_COLS, 4'd3);
        run_multiply();
        settle();
    endtask

    // 2x1 times the transpose of a 3x1
    task automatic test_transpose();
        write_reg(CFG_A_COLS, 4'd1);
        write_reg(CFG_B_COLS, 4'd1);
        write_reg(CFG_B_ROWS, 4'd3);
        run_multiply();
        settle();
    endtask

    // zero acts as one, above the maximum acts as the maximum, mode takes bit 0;
    // an 8-term dot product of the most negative values hits the top of the sum
    task automatic test_size_clamping();
        write_reg(CFG_A_ROWS, 4'd0);
        write_reg(CFG_A_COLS, 4'd15);
        write_reg(CFG_B_ROWS, 4'd9);
        write_reg(CFG_B_COLS, 4'd0);
        write_reg(CFG_TRANS_B, 4'b1110);
        for (int k = 0; k < MAX_DIM; k++) begin
            send_item(FUNC_WR_A, 3'd0, 3'(k), 16'sh8000);
            send_item(FUNC_WR_B, 3'(k), 3'd0, 16'sh8000);
        end
        run_multiply();
        settle();
    endtask

    // phases of random sizes, each with a few load bursts and multiplies
    task automatic test_random_traffic();
        logic [3:0] ar_raw;
        logic [3:0] ac_raw;
        logic [3:0] br_raw;
        logic [3:0] bc_raw;
        bit         tr;
        bit         clash;
        bit         wide;
        int         target;
        int         pick;
        target = live_items + RANDOM_ITEMS;
        while (live_items < target) begin
            // big sizes only now and then, mismatches rarely
            wide   = $urandom_range(0, 99) < 15;
            clash  = $urandom_range(0, 99) < 12;
            tr     = $urandom_range(0, 1);
            ar_raw = pick_size(wide);
            ac_raw = pick_size(wide);
            br_raw = pick_size(wide);
            bc_raw = pick_size(wide);
            if (!clash) begin
                if (tr) begin
                    bc_raw = ac_raw;
                end else begin
                    br_raw = ac_raw;
                end
            end
            burst_mode = $urandom_range(0, 3) == 0;
            write_reg(CFG_A_ROWS, ar_raw);
            write_reg(CFG_A_COLS, ac_raw);
            write_reg(CFG_B_ROWS, br_raw);
            write_reg(CFG_B_COLS, bc_raw);
            write_reg(CFG_TRANS_B, {3'($urandom), tr});
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 10)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        send_item(FUNC_WR_A, 3'($urandom_range(0, eff_dim(m_a_rows) - 1)),
                                  3'($urandom_range(0, eff_dim(m_a_cols) - 1)), rand_value());
                    end else if (pick < 80) begin
                        send_item(FUNC_WR_B, 3'($urandom_range(0, eff_dim(m_b_rows) - 1)),
                                  3'($urandom_range(0, eff_dim(m_b_cols) - 1)), rand_value());
                    end else if (pick < 94) begin
                        // any address, often outside the sizes
                        send_item(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
                                  rand_value());
                    end else begin
                        send_item(FUNC_NONE, 3'($urandom), 3'($urandom), rand_value());
                    end
                end
                run_multiply();
            end
            settle();
        end
        burst_mode = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_output_hold();
        write_reg(CFG_A_ROWS, 4'd3);
        write_reg(CFG_A_COLS, 4'd4);
        write_reg(CFG_B_ROWS, 4'd4);
        write_reg(CFG_B_COLS, 4'd3);
        write_reg(CFG_TRANS_B, 4'd0);
        burst_mode = 1'b1;
        hold_req   = 1'b1;
        wait (long_hold_active);
        hold_req   = 1'b0;
        run_multiply();
        repeat (6) begin
            send_item(FUNC_WR_A, 3'($urandom_range(0, 2)), 3'($urandom_range(0, 3)),
                      rand_value());
        end
        burst_mode = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // receiver stall pattern
    // ------------------------------------------------------------------
    initial begin : out_stall_gen
        int pick;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req && !long_hold_active) begin
                long_hold_active = 1'b1;
                i_out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                    hold_cycles_done++;
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // free-running stretch
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end else if (pick < 90) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                    @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result against the oldest product due
    // ------------------------------------------------------------------
    initial begin : product_checker
        t_product want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                products_seen++;
                if (due_products.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("unexpected result: row %0d col %0d product %0d last %b error %b",
                                 o_out_row, o_out_col, o_product, o_last, o_error);
                    end
                end else begin
                    want = due_products.pop_front();
                    if (o_out_row !== want.row || o_out_col !== want.col ||
                        o_product !== want.product || o_last !== want.last ||
                        o_error !== want.error) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("mismatch: expected row %0d col %0d product %0d last %b error %b",
                                     want.row, want.col, want.product, want.last, want.error);
                            $display("          actual   row %0d col %0d product %0d last %b error %b",
                                     o_out_row, o_out_col, o_product, o_last, o_error);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_WR_A;
        i_row       = '0;
        i_col       = '0;
        i_value     = '0;

        // model starts from the reset sizes, stores unwritten
        m_a_rows = 4'd2;
        m_a_cols = 4'd1;
        m_b_rows = 4'd1;
        m_b_cols = 4'd1;
        m_trans  = 1'b0;
        for (int n = 0; n < STORE_DEPTH; n++) begin
            a_mem[n] = '0;
            b_mem[n] = '0;
            a_set[n] = 1'b0;
            b_set[n] = 1'b0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_sizes();
        test_ignored_items();
        test_dimension_errors();
        test_transpose();
        test_size_clamping();
        test_random_traffic();
        test_output_hold();
        settle();

        $display("covered %0d effective items, %0d multiplies (%0d dimension errors), %0d results",
                 live_items, starts_done, error_runs, products_seen);
        $display("%0d register writes, %0d cycles of output hold-off, %0d products still due",
                 reg_writes, hold_cycles_done, due_products.size());
        if (fault_count == 0 && due_products.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/mme_mac.sv
rtl/core/matrix_multiply_engine.sv
verif/matrix_multiply_engine_test.sv
